FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file of the text console block.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is applied.
`define TCC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is applied.
`define TCC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/tcc_pkg.sv
// Package of the text console character processor: widths, codes, reset values
// and the result item type. No dependencies.
package tcc_pkg;

    localparam int COORD_BITS = 12;
    localparam int CELL_BITS  = 7;
    localparam int COLOR_BITS = 32;
    localparam int COUNT_BITS = 32;
    localparam int CH_BITS    = 8;
    localparam int ROWS_BITS  = 12;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_DRAW   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_SCROLL = 2'd3
    } cmd_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_CHAR_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CHAR_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_LINE_HEIGHT  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_TEXT_HEIGHT  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEFAULT_FG   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEFAULT_BG   = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [CELL_BITS-1:0]  RST_CHAR_WIDTH   = 7'd8;
    localparam logic [CELL_BITS-1:0]  RST_LINE_HEIGHT  = 7'd16;
    localparam logic [COORD_BITS-1:0] RST_SCREEN_WIDTH = 12'd1024;
    localparam logic [COORD_BITS-1:0] RST_TEXT_HEIGHT  = 12'd768;
    localparam logic [COLOR_BITS-1:0] RST_DEFAULT_FG   = 32'h00d8_d8d8;
    localparam logic [COLOR_BITS-1:0] RST_DEFAULT_BG   = 32'h0000_0000;

    // Byte codes.
    localparam logic [CH_BITS-1:0] CH_END       = 8'h00;
    localparam logic [CH_BITS-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CH_BITS-1:0] CH_TAB       = 8'h09;
    localparam logic [CH_BITS-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CH_BITS-1:0] CH_ESC_START = 8'h1A;
    localparam logic [CH_BITS-1:0] CH_COMMA     = 8'h2C;
    localparam logic [CH_BITS-1:0] CH_SEMICOLON = 8'h3B;
    localparam logic [CH_BITS-1:0] CH_DIGIT_0   = 8'h30;
    localparam logic [CH_BITS-1:0] CH_DIGIT_9   = 8'h39;
    localparam logic [CH_BITS-1:0] CH_UPPER_B   = 8'h42;
    localparam logic [CH_BITS-1:0] CH_UPPER_F   = 8'h46;
    localparam logic [CH_BITS-1:0] CH_UPPER_R   = 8'h52;
    localparam logic [CH_BITS-1:0] CH_LOWER_B   = 8'h62;
    localparam logic [CH_BITS-1:0] CH_LOWER_F   = 8'h66;
    localparam logic [CH_BITS-1:0] CH_LOWER_R   = 8'h72;

    localparam logic [ROWS_BITS-1:0] ROWS_MAX = 12'hFFF;

    typedef struct packed {
        cmd_t                  cmd;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [CH_BITS-1:0]    glyph;
        logic [COLOR_BITS-1:0] fg_color;
        logic [COLOR_BITS-1:0] bg_color;
        logic [ROWS_BITS-1:0]  scroll_rows;
        logic [COORD_BITS-1:0] cursor_x_out;
        logic [COORD_BITS-1:0] cursor_y_out;
        logic [COUNT_BITS-1:0] chars_written;
        logic                  last;
    } result_t;

endpackage

FILE: hdl/tcc_interfaces.sv
// Valid/ready channel interfaces of the text console block: text bytes,
// result items and configuration writes. Depends on tcc_pkg.
interface tcc_in_if;
    logic                        valid;
    logic                        ready;
    logic [tcc_pkg::CH_BITS-1:0] ch;
    logic                        end_of_write;

    modport source (output valid, ch, end_of_write, input ready);
    modport sink (input valid, ch, end_of_write, output ready);
endinterface

interface tcc_out_if;
    logic                           valid;
    logic                           ready;
    tcc_pkg::cmd_t                  cmd;
    logic [tcc_pkg::COORD_BITS-1:0] pos_x;
    logic [tcc_pkg::COORD_BITS-1:0] pos_y;
    logic [tcc_pkg::CH_BITS-1:0]    glyph;
    logic [tcc_pkg::COLOR_BITS-1:0] fg_color;
    logic [tcc_pkg::COLOR_BITS-1:0] bg_color;
    logic [tcc_pkg::ROWS_BITS-1:0]  scroll_rows;
    logic [tcc_pkg::COORD_BITS-1:0] cursor_x_out;
    logic [tcc_pkg::COORD_BITS-1:0] cursor_y_out;
    logic [tcc_pkg::COUNT_BITS-1:0] chars_written;
    logic                           last;

    modport source (output valid, cmd, pos_x, pos_y, glyph, fg_color, bg_color,
                    scroll_rows, cursor_x_out, cursor_y_out, chars_written, last,
                    input ready);
    modport sink (input valid, cmd, pos_x, pos_y, glyph, fg_color, bg_color,
                  scroll_rows, cursor_x_out, cursor_y_out, chars_written, last,
                  output ready);
endinterface

interface tcc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tcc_pkg::CFG_IDX_BITS-1:0]  index;
    logic [tcc_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/tcc_rem_unit.sv
// Iterative restoring remainder unit: one dividend bit per cycle.
// Used for the tab stop position. Depends on tcc_pkg.
module tcc_rem_unit #(
    parameter int PW = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [tcc_pkg::COORD_BITS-1:0] dividend,
    input  logic [PW-1:0]                  divisor,
    output logic                           done,
    output logic [PW-1:0]                  remainder
);

    localparam int DW = tcc_pkg::COORD_BITS;
    localparam int CNT_BITS = $clog2(DW + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]       sh_reg, sh_next;
    logic [PW-1:0]       div_reg, div_next;
    logic [PW-1:0]       rem_reg, rem_next;
    logic [PW:0]         trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, sh_reg[DW-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(DW);
            sh_next   = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so one subtract
            // restores it after each shift.
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = PW'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = PW'(trial);
            end
            sh_next  = {sh_reg[DW-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

FILE: hdl/tcc_out_reg.sv
// Output register of the result channel: holds one result item until taken.
// Depends on tcc_pkg and tcc_out_if.
module tcc_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  tcc_pkg::result_t din,
    output logic             can_load,
    tcc_out_if.source        results
);

    logic             valid_reg, valid_next;
    tcc_pkg::result_t data_reg, data_next;

    assign can_load = !valid_reg || results.ready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = din;
        end
        else if (results.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign results.valid         = valid_reg;
    assign results.cmd           = data_reg.cmd;
    assign results.pos_x         = data_reg.pos_x;
    assign results.pos_y         = data_reg.pos_y;
    assign results.glyph         = data_reg.glyph;
    assign results.fg_color      = data_reg.fg_color;
    assign results.bg_color      = data_reg.bg_color;
    assign results.scroll_rows   = data_reg.scroll_rows;
    assign results.cursor_x_out  = data_reg.cursor_x_out;
    assign results.cursor_y_out  = data_reg.cursor_y_out;
    assign results.chars_written = data_reg.chars_written;
    assign results.last          = data_reg.last;

endmodule

FILE: hdl/text_console_char_processor_top.sv
// Top level of the text console character processor: sequencer, state and
// configuration. Depends on tcc_pkg, tcc_interfaces, tcc_rem_unit, tcc_out_reg.
//
//   channel  | dir | payload                                  | accepted when
//   chars    | in  | ch, end_of_write                         | valid && ready
//   results  | out | cmd, pos, glyph, colors, rows, cursor... | valid && ready
//   cfg      | in  | index, data                              | valid && ready
//
// A byte passes the accept, decode and cursor update states, then one emit state per
// result item; escape and ignored bytes skip the update. A tab also waits in the tab
// wait state for the remainder unit's twelve bit steps and the step add.
// Each byte gives one or two result items, the last one marked last.
// Reset is asynchronous and needs no clearing pass; cfg is always ready.
// A stalled result channel holds the sequencer in its emit state.
module text_console_char_processor_top #(
    parameter int TAB_STOP = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    tcc_in_if.sink    chars,
    tcc_out_if.source results,
    tcc_cfg_if.sink   cfg
);

    localparam int CB = tcc_pkg::COORD_BITS;
    localparam int PW = $clog2(TAB_STOP * ((1 << tcc_pkg::CELL_BITS) - 1) + 1);
    localparam int XW = ((CB > PW) ? CB : PW) + 1;
    localparam int YW = CB + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TAB_WAIT,
        ST_ADVANCE,
        ST_EMIT_A,
        ST_EMIT_B
    } state_t;

    typedef struct packed {
        logic                           active;
        logic                           target_bg;
        logic [tcc_pkg::COLOR_BITS-1:0] color;
        logic [tcc_pkg::COLOR_BITS-1:0] channel;
        logic [1:0]                     index;
    } esc_t;

    state_t                         state_reg, state_next;
    logic [tcc_pkg::CH_BITS-1:0]    ch_reg, ch_next;
    logic                           eow_reg, eow_next;
    logic                           ends_reg, ends_next;
    logic                           draining_reg, draining_next;
    logic [CB-1:0]                  cursor_x_reg, cursor_x_next;
    logic [CB-1:0]                  cursor_y_reg, cursor_y_next;
    logic [tcc_pkg::COLOR_BITS-1:0] cur_fg_reg, cur_fg_next;
    logic [tcc_pkg::COLOR_BITS-1:0] cur_bg_reg, cur_bg_next;
    esc_t                           esc_reg, esc_next;
    logic [tcc_pkg::COUNT_BITS-1:0] write_count_reg, write_count_next;
    logic [XW-1:0]                  x_new_reg, x_new_next;
    tcc_pkg::result_t               first_reg, first_next;
    logic                           has_first_reg, has_first_next;
    logic                           has_scroll_reg, has_scroll_next;
    logic [tcc_pkg::ROWS_BITS-1:0]  scroll_rows_reg, scroll_rows_next;

    logic [tcc_pkg::CELL_BITS-1:0]  cw_reg, cw_next;
    logic [tcc_pkg::CELL_BITS-1:0]  lh_reg, lh_next;
    logic [CB-1:0]                  sw_reg, sw_next;
    logic [CB-1:0]                  th_reg, th_next;
    logic [tcc_pkg::COLOR_BITS-1:0] dfg_reg, dfg_next;
    logic [tcc_pkg::COLOR_BITS-1:0] dbg_reg, dbg_next;

    logic [PW-1:0]    period;
    logic             rem_start;
    logic             rem_done;
    logic [PW-1:0]    rem_value;
    logic             out_load;
    logic             out_can_load;
    tcc_pkg::result_t out_data;
    tcc_pkg::result_t scroll_res;
    logic [CB-1:0]    x_back;
    logic [YW-1:0]    y_one;
    logic [YW-1:0]    y_sum;
    logic [YW-1:0]    y_off;
    logic             is_put;

    assign chars.ready = (state_reg == ST_IDLE);
    assign cfg.ready   = 1'b1;
    assign period      = PW'(TAB_STOP) * PW'(cw_reg);

    tcc_rem_unit #(
        .PW (PW)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (cursor_x_reg),
        .divisor   (period),
        .done      (rem_done),
        .remainder (rem_value)
    );

    tcc_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (out_load),
        .din      (out_data),
        .can_load (out_can_load),
        .results  (results)
    );

    // Configuration writes.
    always_comb
    begin
        cw_next  = cw_reg;
        lh_next  = lh_reg;
        sw_next  = sw_reg;
        th_next  = th_reg;
        dfg_next = dfg_reg;
        dbg_next = dbg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                tcc_pkg::REG_CHAR_WIDTH:   cw_next  = cfg.data[tcc_pkg::CELL_BITS-1:0];
                tcc_pkg::REG_CHAR_HEIGHT:
                begin
                    // The cell height matters only to the drawing side.
                end
                tcc_pkg::REG_LINE_HEIGHT:  lh_next  = cfg.data[tcc_pkg::CELL_BITS-1:0];
                tcc_pkg::REG_SCREEN_WIDTH: sw_next  = cfg.data[CB-1:0];
                tcc_pkg::REG_TEXT_HEIGHT:  th_next  = cfg.data[CB-1:0];
                tcc_pkg::REG_DEFAULT_FG:   dfg_next = cfg.data;
                tcc_pkg::REG_DEFAULT_BG:   dbg_next = cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        scroll_res             = '0;
        scroll_res.cmd         = tcc_pkg::CMD_SCROLL;
        scroll_res.bg_color    = dbg_reg;
        scroll_res.scroll_rows = scroll_rows_reg;
    end

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        ch_next          = ch_reg;
        eow_next         = eow_reg;
        ends_next        = ends_reg;
        draining_next    = draining_reg;
        cursor_x_next    = cursor_x_reg;
        cursor_y_next    = cursor_y_reg;
        cur_fg_next      = cur_fg_reg;
        cur_bg_next      = cur_bg_reg;
        esc_next         = esc_reg;
        write_count_next = write_count_reg;
        x_new_next       = x_new_reg;
        first_next       = first_reg;
        has_first_next   = has_first_reg;
        has_scroll_next  = has_scroll_reg;
        scroll_rows_next = scroll_rows_reg;
        rem_start        = 1'b0;
        out_load         = 1'b0;
        out_data         = '0;
        is_put           = 1'b0;
        x_back           = (cursor_x_reg > CB'(cw_reg)) ? cursor_x_reg - CB'(cw_reg) : '0;
        y_one            = YW'(cursor_y_reg) + YW'(lh_reg);
        y_sum            = y_one + YW'(lh_reg);
        y_off            = y_sum - YW'(th_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (chars.valid)
                begin
                    ch_next    = chars.ch;
                    eow_next   = chars.end_of_write;
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                ends_next       = eow_reg;
                has_first_next  = 1'b0;
                has_scroll_next = 1'b0;
                first_next      = '0;
                state_next      = ST_EMIT_A;
                if (draining_reg)
                begin
                    // Rest of a write after a zero byte is ignored.
                end
                else if (ch_reg == tcc_pkg::CH_END)
                begin
                    ends_next = 1'b1;
                    if (!eow_reg)
                    begin
                        draining_next = 1'b1;
                    end
                end
                else if (esc_reg.active)
                begin
                    case (ch_reg) inside
                        tcc_pkg::CH_SEMICOLON:
                        begin
                            if (esc_reg.target_bg)
                            begin
                                cur_bg_next = esc_reg.color | esc_reg.channel;
                            end
                            else
                            begin
                                cur_fg_next = esc_reg.color | esc_reg.channel;
                            end
                            esc_next = '0;
                        end
                        tcc_pkg::CH_LOWER_B, tcc_pkg::CH_UPPER_B:
                            esc_next.target_bg = 1'b1;
                        tcc_pkg::CH_LOWER_F, tcc_pkg::CH_UPPER_F:
                            esc_next.target_bg = 1'b0;
                        tcc_pkg::CH_LOWER_R, tcc_pkg::CH_UPPER_R:
                            esc_next.color = esc_reg.target_bg ? dbg_reg : dfg_reg;
                        tcc_pkg::CH_COMMA:
                        begin
                            // The first three channels land at bits 16, 8 and 0;
                            // later ones are dropped.
                            case (esc_reg.index)
                                2'd0: esc_next.color = esc_reg.color | (esc_reg.channel << 16);
                                2'd1: esc_next.color = esc_reg.color | (esc_reg.channel << 8);
                                2'd2: esc_next.color = esc_reg.color | esc_reg.channel;
                                default: esc_next.color = esc_reg.color;
                            endcase
                            if (esc_reg.index != 2'd3)
                            begin
                                esc_next.index = esc_reg.index + 2'd1;
                            end
                            esc_next.channel = '0;
                        end
                        [tcc_pkg::CH_DIGIT_0:tcc_pkg::CH_DIGIT_9]:
                            esc_next.channel = (esc_reg.channel << 3) + (esc_reg.channel << 1)
                                + 32'(ch_reg - tcc_pkg::CH_DIGIT_0);
                        default:
                        begin
                        end
                    endcase
                end
                else if (ch_reg == tcc_pkg::CH_ESC_START)
                begin
                    esc_next        = '0;
                    esc_next.active = 1'b1;
                end
                else
                begin
                    is_put = 1'b1;
                end

                if (is_put)
                begin
                    write_count_next = write_count_reg + 32'd1;
                    state_next       = ST_ADVANCE;
                    case (ch_reg)
                        tcc_pkg::CH_BACKSPACE:
                        begin
                            first_next.cmd      = tcc_pkg::CMD_CLEAR;
                            first_next.pos_x    = x_back;
                            first_next.pos_y    = cursor_y_reg;
                            first_next.bg_color = dbg_reg;
                            has_first_next      = 1'b1;
                            x_new_next          = XW'(x_back);
                        end
                        tcc_pkg::CH_TAB:
                        begin
                            x_new_next = XW'(cursor_x_reg);
                            if (period != '0)
                            begin
                                rem_start  = 1'b1;
                                state_next = ST_TAB_WAIT;
                            end
                        end
                        tcc_pkg::CH_NEWLINE:
                            x_new_next = XW'(cursor_x_reg);
                        default:
                        begin
                            first_next.cmd      = tcc_pkg::CMD_DRAW;
                            first_next.pos_x    = cursor_x_reg;
                            first_next.pos_y    = cursor_y_reg;
                            first_next.glyph    = ch_reg;
                            first_next.fg_color = cur_fg_reg;
                            first_next.bg_color = cur_bg_reg;
                            has_first_next      = 1'b1;
                            x_new_next          = XW'(cursor_x_reg) + XW'(cw_reg);
                        end
                    endcase
                end
            end

            ST_TAB_WAIT:
            begin
                if (rem_done)
                begin
                    x_new_next = XW'(cursor_x_reg) + XW'(period) - XW'(rem_value);
                    state_next = ST_ADVANCE;
                end
            end

            ST_ADVANCE:
            begin
                state_next = ST_EMIT_A;
                if (x_new_reg >= XW'(sw_reg) || ch_reg == tcc_pkg::CH_NEWLINE)
                begin
                    cursor_x_next = '0;
                    if (y_sum > YW'(th_reg))
                    begin
                        // The next line would run past the text area: scroll by
                        // the excess and park the cursor on the last full line.
                        has_scroll_next  = 1'b1;
                        scroll_rows_next = (y_off > YW'(tcc_pkg::ROWS_MAX))
                            ? tcc_pkg::ROWS_MAX : y_off[tcc_pkg::ROWS_BITS-1:0];
                        cursor_y_next = (th_reg > CB'(lh_reg)) ? th_reg - CB'(lh_reg) : '0;
                    end
                    else
                    begin
                        cursor_y_next = y_one[CB-1:0];
                    end
                end
                else
                begin
                    cursor_x_next = x_new_reg[CB-1:0];
                end
            end

            ST_EMIT_A, ST_EMIT_B:
            begin
                if (has_first_reg && state_reg == ST_EMIT_A)
                begin
                    out_data = first_reg;
                end
                else if (has_scroll_reg)
                begin
                    out_data = scroll_res;
                end
                out_data.cursor_x_out  = cursor_x_reg;
                out_data.cursor_y_out  = cursor_y_reg;
                out_data.chars_written = write_count_reg;
                out_data.last = (state_reg == ST_EMIT_B) || !(has_first_reg && has_scroll_reg);
                if (out_can_load)
                begin
                    out_load = 1'b1;
                    if (!out_data.last)
                    begin
                        state_next = ST_EMIT_B;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                        if (ends_reg)
                        begin
                            esc_next    = '0;
                            cur_fg_next = dfg_reg;
                            cur_bg_next = dbg_reg;
                        end
                        if (eow_reg)
                        begin
                            write_count_next = '0;
                            draining_next    = 1'b0;
                        end
                    end
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            draining_reg    <= 1'b0;
            cursor_x_reg    <= '0;
            cursor_y_reg    <= '0;
            cur_fg_reg      <= tcc_pkg::RST_DEFAULT_FG;
            cur_bg_reg      <= tcc_pkg::RST_DEFAULT_BG;
            esc_reg         <= '0;
            write_count_reg <= '0;
            has_first_reg   <= 1'b0;
            has_scroll_reg  <= 1'b0;
            ends_reg        <= 1'b0;
            cw_reg          <= tcc_pkg::RST_CHAR_WIDTH;
            lh_reg          <= tcc_pkg::RST_LINE_HEIGHT;
            sw_reg          <= tcc_pkg::RST_SCREEN_WIDTH;
            th_reg          <= tcc_pkg::RST_TEXT_HEIGHT;
            dfg_reg         <= tcc_pkg::RST_DEFAULT_FG;
            dbg_reg         <= tcc_pkg::RST_DEFAULT_BG;
            ch_reg          <= '0;
            eow_reg         <= 1'b0;
            x_new_reg       <= '0;
            first_reg       <= '0;
            scroll_rows_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            draining_reg    <= draining_next;
            cursor_x_reg    <= cursor_x_next;
            cursor_y_reg    <= cursor_y_next;
            cur_fg_reg      <= cur_fg_next;
            cur_bg_reg      <= cur_bg_next;
            esc_reg         <= esc_next;
            write_count_reg <= write_count_next;
            has_first_reg   <= has_first_next;
            has_scroll_reg  <= has_scroll_next;
            ends_reg        <= ends_next;
            cw_reg          <= cw_next;
            lh_reg          <= lh_next;
            sw_reg          <= sw_next;
            th_reg          <= th_next;
            dfg_reg         <= dfg_next;
            dbg_reg         <= dbg_next;
            ch_reg          <= ch_next;
            eow_reg         <= eow_next;
            x_new_reg       <= x_new_next;
            first_reg       <= first_next;
            scroll_rows_reg <= scroll_rows_next;
        end
    end

endmodule

FILE: hdl/tcc_checker.sv
// Port-level checker of the text console block and its bind to the top level.
// Depends on tcc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tcc_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input tcc_pkg::cmd_t out_cmd,
    input logic [tcc_pkg::COORD_BITS-1:0] out_pos_x,
    input logic          out_last
);

    // A waiting result item stays offered.
    `TCC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result item dropped while stalled")

    // Taking a byte starts the sequencer, so the input closes right after.
    `TCC_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "byte taken while busy")

    // A scroll is always the final item of its byte and carries no position.
    `TCC_ASSERT(a_scroll_last, out_valid && out_cmd == tcc_pkg::CMD_SCROLL |-> out_last && out_pos_x == '0, "scroll item not final")

    // A byte with no drawing work gives exactly one empty item.
    `TCC_ASSERT(a_none_last, out_valid && out_cmd == tcc_pkg::CMD_NONE |-> out_last, "empty item not final")

    // Reset empties the result channel by the next clock edge.
    `TCC_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result offered in reset")

endmodule

bind text_console_char_processor_top tcc_checker u_tcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chars.valid),
    .in_ready  (chars.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_cmd   (results.cmd),
    .out_pos_x (results.pos_x),
    .out_last  (results.last)
);

FILE: tb/sv/tb_text_console_char_processor_top.sv
// Self-checking testbench of the text console character processor: drives text
// bytes and register writes, predicts every result item and compares them.
// Depends on tcc_pkg, the tcc channel interfaces and the top-level block.
module tb_text_console_char_processor_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tcc_pkg::*;

    localparam int TAB_STOP       = 8;
    localparam int HOLD_CYCLES    = 600;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_ITEMS    = 170;
    localparam int RANDOM_PHASES  = 6;
    localparam logic [CELL_BITS-1:0] RST_CHAR_HEIGHT = 7'd16;

    typedef struct packed {
        logic [CH_BITS-1:0] ch;
        logic               eow;
    } char_item_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                     in_valid  = 1'b0;
    logic [CH_BITS-1:0]       in_ch     = '0;
    logic                     in_eow    = 1'b0;
    logic                     out_ready = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    tcc_in_if  chars_if();
    tcc_out_if results_if();
    tcc_cfg_if cfg_if();

    assign chars_if.valid        = in_valid;
    assign chars_if.ch           = in_ch;
    assign chars_if.end_of_write = in_eow;
    assign results_if.ready      = out_ready;
    assign cfg_if.valid          = cfg_valid;
    assign cfg_if.index          = cfg_index;
    assign cfg_if.data           = cfg_data;

    text_console_char_processor_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (results_if),
        .cfg     (cfg_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Register copies seen by the console model.
    logic [CELL_BITS-1:0]  cell_w    = RST_CHAR_WIDTH;
    logic [CELL_BITS-1:0]  cell_h    = RST_CHAR_HEIGHT;
    logic [CELL_BITS-1:0]  line_step = RST_LINE_HEIGHT;
    logic [COORD_BITS-1:0] wrap_x    = RST_SCREEN_WIDTH;
    logic [COORD_BITS-1:0] text_h    = RST_TEXT_HEIGHT;
    logic [COLOR_BITS-1:0] def_fg    = RST_DEFAULT_FG;
    logic [COLOR_BITS-1:0] def_bg    = RST_DEFAULT_BG;

    // Console state.
    logic [COORD_BITS-1:0] cur_x       = '0;
    logic [COORD_BITS-1:0] cur_y       = '0;
    logic [COLOR_BITS-1:0] cur_fg      = RST_DEFAULT_FG;
    logic [COLOR_BITS-1:0] cur_bg      = RST_DEFAULT_BG;
    logic                  esc_open    = 1'b0;
    logic                  esc_bg      = 1'b0;
    logic [COLOR_BITS-1:0] esc_col     = '0;
    logic [COLOR_BITS-1:0] esc_chan    = '0;
    int                    esc_idx     = 0;
    logic [COUNT_BITS-1:0] write_count = '0;
    logic                  skipping    = 1'b0;

    char_item_t text_queue[$];
    char_item_t text_run[$];
    result_t    byte_results[$];
    result_t    expected_results[$];

    int   mismatches = 0;
    int   burst_left = 0;
    int   gap_left   = 0;
    int   stall_mode = 0;
    int   mode_left  = 0;
    int   hold_left  = 0;
    logic hold_done  = 1'b0;
    logic hold_request = 1'b0;

    function automatic void emit_result(input cmd_t c, input int px, input int py,
                                        input logic [CH_BITS-1:0] g,
                                        input logic [COLOR_BITS-1:0] fg,
                                        input logic [COLOR_BITS-1:0] bg,
                                        input int rows);
        result_t r;
        r = '0;
        r.cmd         = c;
        r.pos_x       = px[COORD_BITS-1:0];
        r.pos_y       = py[COORD_BITS-1:0];
        r.glyph       = g;
        r.fg_color    = fg;
        r.bg_color    = bg;
        r.scroll_rows = rows[ROWS_BITS-1:0];
        byte_results.push_back(r);
    endfunction

    function automatic void drop_escape();
        esc_open = 1'b0;
        esc_bg   = 1'b0;
        esc_col  = '0;
        esc_chan = '0;
        esc_idx  = 0;
    endfunction

    function automatic void next_line();
        int y;
        int rem;
        int off;
        y = int'(cur_y) + int'(line_step);
        rem = int'(text_h) - (y + int'(line_step));
        cur_x = '0;
        if (rem < 0)
        begin
            off = -rem;
            y = (y > off) ? y - off : 0;
            emit_result(CMD_SCROLL, 0, 0, '0, '0, def_bg,
                        (off > int'(ROWS_MAX)) ? int'(ROWS_MAX) : off);
        end
        cur_y = y[COORD_BITS-1:0];
    endfunction

    function automatic void put_char(input logic [CH_BITS-1:0] c);
        int x;
        int period;
        x = int'(cur_x);
        if (c == CH_BACKSPACE)
        begin
            x = (x > int'(cell_w)) ? x - int'(cell_w) : 0;
            emit_result(CMD_CLEAR, x, int'(cur_y), '0, '0, def_bg, 0);
        end
        else if (c == CH_TAB)
        begin
            period = TAB_STOP * int'(cell_w);
            if (period != 0)
                x += period - (x % period);
        end
        else if (c != CH_NEWLINE)
        begin
            emit_result(CMD_DRAW, x, int'(cur_y), c, cur_fg, cur_bg, 0);
            x += int'(cell_w);
        end
        if (x >= int'(wrap_x) || c == CH_NEWLINE)
            next_line();
        else
            cur_x = x[COORD_BITS-1:0];
    endfunction

    function automatic void escape_char(input logic [CH_BITS-1:0] c);
        if (c == CH_LOWER_B || c == CH_UPPER_B)
            esc_bg = 1'b1;
        else if (c == CH_LOWER_F || c == CH_UPPER_F)
            esc_bg = 1'b0;
        else if (c == CH_LOWER_R || c == CH_UPPER_R)
            esc_col = esc_bg ? def_bg : def_fg;
        else if (c == CH_COMMA)
        begin
            // Channels ended by the fourth comma or later are dropped.
            if (esc_idx < 3)
            begin
                esc_col |= esc_chan << (16 - 8 * esc_idx);
                esc_idx++;
            end
            esc_chan = '0;
        end
        else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
            esc_chan = esc_chan * 10 + COLOR_BITS'(c - CH_DIGIT_0);
    endfunction

    function automatic void predict_byte(input char_item_t it);
        logic    ends;
        result_t r;
        ends = it.eow;
        byte_results.delete();
        if (!skipping)
        begin
            if (it.ch == CH_END)
            begin
                // The rest of this write is ignored.
                ends = 1'b1;
                if (!it.eow)
                    skipping = 1'b1;
            end
            else if (esc_open)
            begin
                if (it.ch == CH_SEMICOLON)
                begin
                    if (esc_bg)
                        cur_bg = esc_col | esc_chan;
                    else
                        cur_fg = esc_col | esc_chan;
                    drop_escape();
                end
                else
                    escape_char(it.ch);
            end
            else if (it.ch == CH_ESC_START)
            begin
                drop_escape();
                esc_open = 1'b1;
            end
            else
            begin
                put_char(it.ch);
                write_count++;
            end
        end
        if (ends)
        begin
            drop_escape();
            cur_fg = def_fg;
            cur_bg = def_bg;
        end
        if (byte_results.size() == 0)
            emit_result(CMD_NONE, 0, 0, '0, '0, '0, 0);
        foreach (byte_results[i])
        begin
            r = byte_results[i];
            r.cursor_x_out  = cur_x;
            r.cursor_y_out  = cur_y;
            r.chars_written = write_count;
            r.last          = (i == byte_results.size() - 1);
            expected_results.push_back(r);
        end
        if (it.eow)
        begin
            write_count = '0;
            skipping    = 1'b0;
        end
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                      input logic [CFG_DATA_BITS-1:0] value);
        case (idx)
            REG_CHAR_WIDTH:   cell_w    = value[CELL_BITS-1:0];
            REG_CHAR_HEIGHT:  cell_h    = value[CELL_BITS-1:0];
            REG_LINE_HEIGHT:  line_step = value[CELL_BITS-1:0];
            REG_SCREEN_WIDTH: wrap_x    = value[COORD_BITS-1:0];
            REG_TEXT_HEIGHT:  text_h    = value[COORD_BITS-1:0];
            REG_DEFAULT_FG:   def_fg    = value;
            REG_DEFAULT_BG:   def_bg    = value;
            default: ;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        apply_reg(idx, value);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_phase(input int p);
        int cw, ch, lh, sw, th;
        logic [COLOR_BITS-1:0] fg, bg;
        fg = $urandom();
        bg = $urandom();
        case (p)
            0: begin cw = 8;   ch = 16;  lh = 16;  sw = 1024; th = 768;  end
            1: begin cw = 1;   ch = 1;   lh = 1;   sw = 1;    th = 1;
                     fg = '0;  bg = '0; end
            2: begin cw = 127; ch = 127; lh = 127; sw = 4095; th = 4095;
                     fg = '1;  bg = '1; end
            // Zero cell width, and a line taller than the text area.
            3: begin cw = 0;   ch = 64;  lh = 64;  sw = 100;  th = 50;   end
            default:
            begin
                cw = $urandom_range(1, 64);
                ch = $urandom_range(1, 64);
                lh = $urandom_range(1, 64);
                sw = $urandom_range(16, 640);
                th = $urandom_range(16, 400);
            end
        endcase
        write_reg(REG_CHAR_WIDTH,   CFG_DATA_BITS'(cw));
        write_reg(REG_CHAR_HEIGHT,  CFG_DATA_BITS'(ch));
        write_reg(REG_LINE_HEIGHT,  CFG_DATA_BITS'(lh));
        write_reg(REG_SCREEN_WIDTH, CFG_DATA_BITS'(sw));
        write_reg(REG_TEXT_HEIGHT,  CFG_DATA_BITS'(th));
        write_reg(REG_DEFAULT_FG,   fg);
        write_reg(REG_DEFAULT_BG,   bg);
    endtask

    function automatic void add_char(input logic [CH_BITS-1:0] c, input logic eow);
        char_item_t it;
        it.ch  = c;
        it.eow = eow;
        text_queue.push_back(it);
    endfunction

    function automatic void run_char(input logic [CH_BITS-1:0] c);
        char_item_t it;
        it.ch  = c;
        it.eow = 1'b0;
        text_run.push_back(it);
    endfunction

    function automatic void run_escape();
        int n_chan;
        int n_dig;
        run_char(CH_ESC_START);
        case ($urandom_range(0, 4))
            0: run_char(CH_LOWER_F);
            1: run_char(CH_LOWER_B);
            2: run_char(CH_UPPER_F);
            3: run_char(CH_UPPER_B);
            default: ;
        endcase
        if ($urandom_range(0, 5) == 0)
            run_char(($urandom_range(0, 1) == 0) ? CH_LOWER_R : CH_UPPER_R);
        n_chan = $urandom_range(0, 5);
        for (int c = 0; c < n_chan; c++)
        begin
            n_dig = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 3);
            for (int d = 0; d < n_dig; d++)
                run_char(CH_DIGIT_0 + CH_BITS'($urandom_range(0, 9)));
            if ($urandom_range(0, 12) == 0)
                run_char(CH_BITS'($urandom_range(0, 255)));
            if (c < n_chan - 1)
                run_char(CH_COMMA);
        end
        // Most escapes are closed; an open one runs into the end of the write.
        if ($urandom_range(0, 6) != 0)
            run_char(CH_SEMICOLON);
    endfunction

    // Queues one write call of random content and returns its length.
    function automatic int queue_random_write();
        int len;
        int kind;
        char_item_t it;
        text_run.delete();
        len = $urandom_range(1, 14);
        while (text_run.size() < len)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 55)
                run_char(CH_BITS'($urandom_range(8'h20, 8'h7E)));
            else if (kind < 62)
                run_char(CH_BACKSPACE);
            else if (kind < 67)
                run_char(CH_TAB);
            else if (kind < 78)
                run_char(CH_NEWLINE);
            else if (kind < 88)
                run_escape();
            else if (kind < 97)
                run_char(CH_BITS'($urandom_range(0, 255)));
            else
                run_char(CH_END);
        end
        foreach (text_run[i])
        begin
            it = text_run[i];
            it.eow = (i == text_run.size() - 1);
            text_queue.push_back(it);
        end
        return text_run.size();
    endfunction

    function automatic void queue_directed();
        add_char(CH_BACKSPACE, 1'b0);   // at the left edge
        add_char(8'h41, 1'b0);
        add_char(8'hFF, 1'b0);
        add_char(8'h01, 1'b0);
        add_char(CH_TAB, 1'b0);
        add_char(CH_BACKSPACE, 1'b0);
        add_char(CH_NEWLINE, 1'b0);
        // Background escape with a channel after the fourth comma.
        add_char(CH_ESC_START, 1'b0);
        add_char(CH_UPPER_B, 1'b0);
        add_char(CH_DIGIT_9, 1'b0);
        add_char(CH_COMMA, 1'b0);
        add_char(CH_COMMA, 1'b0);
        add_char(CH_COMMA, 1'b0);
        add_char(CH_COMMA, 1'b0);
        add_char(CH_DIGIT_0 + 8'd7, 1'b0);
        add_char(CH_SEMICOLON, 1'b0);
        add_char(8'h78, 1'b0);
        // Escape left open when the write ends.
        add_char(CH_ESC_START, 1'b0);
        add_char(CH_UPPER_F, 1'b0);
        add_char(CH_UPPER_R, 1'b0);
        add_char(8'h51, 1'b1);
        // Zero byte in the middle of a write.
        add_char(CH_END, 1'b0);
        add_char(8'h71, 1'b0);
        add_char(8'h71, 1'b1);
    endfunction

    task automatic wait_drained();
        while (text_queue.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            mismatches++;
        end
    endtask

    // Byte sender: bursts of items separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        logic offer;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_ch    <= '0;
            in_eow   <= 1'b0;
        end
        else
        begin
            offer = in_valid;
            if (in_valid && chars_if.ready)
            begin
                predict_byte(text_queue.pop_front());
                offer = 1'b0;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
            if (!offer)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (text_queue.size() > 0)
                    offer = 1'b1;
            end
            in_valid <= offer;
            if (offer)
            begin
                in_ch  <= text_queue[0].ch;
                in_eow <= text_queue[0].eow;
            end
        end
    end

    // One long hold-off of the result channel, started once on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_request && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Result receiver and checker.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        logic    rdy;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (results_if.valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result item with no expectation waiting");
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("cmd", 32'(want.cmd), 32'(results_if.cmd));
                    check_field("pos_x", 32'(want.pos_x), 32'(results_if.pos_x));
                    check_field("pos_y", 32'(want.pos_y), 32'(results_if.pos_y));
                    check_field("glyph", 32'(want.glyph), 32'(results_if.glyph));
                    check_field("fg_color", want.fg_color, results_if.fg_color);
                    check_field("bg_color", want.bg_color, results_if.bg_color);
                    check_field("scroll_rows", 32'(want.scroll_rows),
                                32'(results_if.scroll_rows));
                    check_field("cursor_x_out", 32'(want.cursor_x_out),
                                32'(results_if.cursor_x_out));
                    check_field("cursor_y_out", 32'(want.cursor_y_out),
                                32'(results_if.cursor_y_out));
                    check_field("chars_written", want.chars_written,
                                results_if.chars_written);
                    check_field("last", 32'(want.last), 32'(results_if.last));
                end
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(8, 80);
            end
            else
                mode_left--;
            case (stall_mode)
                0: rdy = 1'b1;
                1: rdy = ($urandom_range(0, 3) != 0);
                2: rdy = ($urandom_range(0, 3) == 0);
                default: rdy = (mode_left % 6) < 2;
            endcase
            out_ready <= rdy && (hold_left == 0);
        end
    end

    initial
    begin
        int queued;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        queue_directed();
        wait_drained();
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            program_phase(p);
            @(negedge clk);
            queued = 0;
            while (queued < PHASE_ITEMS)
                queued += queue_random_write();
            // The receiver stops for a long time while the sender keeps offering.
            if (p == 0)
                hold_request = 1'b1;
            wait_drained();
        end
        if (mismatches == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: text_console_char_processor_top.f
+incdir+hdl
hdl/tcc_pkg.sv
hdl/tcc_interfaces.sv
hdl/tcc_rem_unit.sv
hdl/tcc_out_reg.sv
hdl/text_console_char_processor_top.sv
hdl/tcc_checker.sv
tb/sv/tb_text_console_char_processor_top.sv
